FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files; the core top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold whenever ante holds, checked on every clock outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cond must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

FILE: rtl/unrc_pkg.sv
// Types and constants of the UTF-8 name rule checker.
package unrc_pkg;

	typedef enum logic [2:0] {
		VERDICT_OK,
		VERDICT_BAD_UTF8,
		VERDICT_LEAD_DIGIT,
		VERDICT_LEAD_UNDERLINE,
		VERDICT_BAD_CHAR,
		VERDICT_TRAIL_UNDERLINE,
		VERDICT_SHORT,
		VERDICT_LONG
	} verdict_t;

	typedef enum logic [2:0] {
		KIND_ASCII,
		KIND_LEAD2,
		KIND_LEAD3,
		KIND_LEAD4,
		KIND_CONT,
		KIND_INVALID
	} byte_kind_t;

	typedef enum logic {
		CFG_MIN_CHARS = 1'b0,
		CFG_MAX_CHARS = 1'b1
	} cfg_index_t;

	localparam logic [7:0] COUNT_LIMIT = 8'd255;

	localparam logic [20:0] CP_UNDERLINE = 21'h00005F;
	localparam logic [20:0] CP_DIGIT_LO  = 21'h000030;
	localparam logic [20:0] CP_DIGIT_HI  = 21'h000039;
	localparam logic [20:0] CP_LOWER_LO  = 21'h000061;
	localparam logic [20:0] CP_LOWER_HI  = 21'h00007A;
	localparam logic [20:0] CP_CJK_LO    = 21'h004E00;
	localparam logic [20:0] CP_CJK_HI    = 21'h009FA5;
	localparam logic [20:0] CP_PAREN_L   = 21'h00FF08;
	localparam logic [20:0] CP_PAREN_R   = 21'h00FF09;
	localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
	localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
	localparam logic [20:0] CP_MAX       = 21'h10FFFF;
	localparam logic [20:0] CP_2BYTE     = 21'h000080;
	localparam logic [20:0] CP_3BYTE     = 21'h000800;
	localparam logic [20:0] CP_4BYTE     = 21'h010000;

	// one classified input item as it sits in the item queue
	typedef struct packed {
		logic       has_byte;
		logic       is_end;
		byte_kind_t kind;
		logic [6:0] payload;
	} item_t;

	typedef struct packed {
		verdict_t   verdict;
		logic [8:0] char_count;
	} result_t;

endpackage

FILE: rtl/unrc_queue.sv
// Small first-in first-out queue of fixed-width entries.
module unrc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// DEPTH must be a power of two, not checked here, so that the pointers wrap by themselves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= PW'(wr_ptr_q + 1'b1);
			end
			if (rd_en) begin
				rd_ptr_q <= PW'(rd_ptr_q + 1'b1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (!wr_en && rd_en) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end
endmodule

FILE: rtl/unrc_front.sv
// Front end: accepts input transactions and classifies each byte for the decoder.
module unrc_front (
	input  logic           push,
	input  logic           queue_full,
	input  logic [7:0]     name_byte,
	input  logic           has_byte,
	input  logic           is_end,
	output logic           item_wr,
	output unrc_pkg::item_t item
);
	import unrc_pkg::*;

	assign item_wr = push && !queue_full;

	always_comb begin
		item.has_byte = has_byte;
		item.is_end   = is_end;
		if (name_byte inside {[8'h00:8'h7F]}) begin
			item.kind    = KIND_ASCII;
			item.payload = name_byte[6:0];
		end else if (name_byte inside {[8'h80:8'hBF]}) begin
			item.kind    = KIND_CONT;
			item.payload = {1'b0, name_byte[5:0]};
		end else if (name_byte inside {[8'hC0:8'hDF]}) begin
			item.kind    = KIND_LEAD2;
			item.payload = {2'b00, name_byte[4:0]};
		end else if (name_byte inside {[8'hE0:8'hEF]}) begin
			item.kind    = KIND_LEAD3;
			item.payload = {3'b000, name_byte[3:0]};
		end else if (name_byte inside {[8'hF0:8'hF7]}) begin
			item.kind    = KIND_LEAD4;
			item.payload = {4'b0000, name_byte[2:0]};
		end else begin
			item.kind    = KIND_INVALID;
			item.payload = '0;
		end
	end
endmodule

FILE: rtl/unrc_back.sv
// Back end: UTF-8 sequence decoder, character rule checks and end-of-name verdict.
module unrc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  unrc_pkg::item_t   item,
	output logic              item_pop,
	input  logic              res_full,
	output logic              res_push,
	output unrc_pkg::result_t res,
	input  logic [7:0]        min_chars,
	input  logic [7:0]        max_chars
);
	import unrc_pkg::*;

	logic       stopped_q;
	verdict_t   err_q;
	logic [1:0] pend_q;
	logic [1:0] seqlen_q;
	logic [20:0] accum_q;
	logic [8:0] chars_q;
	logic       lwu_q;

	logic       n_stopped;
	verdict_t   n_err;
	logic [1:0] n_pend;
	logic [1:0] n_seqlen;
	logic [20:0] n_accum;
	logic [8:0] n_chars;
	logic       n_lwu;

	logic       fin;
	logic [1:0] need;
	logic [7:0] limit;
	logic       is_us;
	logic       is_digit;
	logic       allowed;
	logic       end_stop;
	verdict_t   end_err;
	verdict_t   verdict;

	assign item_pop = item_valid && (!item.is_end || !res_full);
	assign res_push = item_pop && item.is_end;
	assign limit    = (max_chars < COUNT_LIMIT) ? max_chars : COUNT_LIMIT;

	// classes of the code point as it stands after this byte
	assign is_us    = (n_accum == CP_UNDERLINE);
	assign is_digit = (n_accum >= CP_DIGIT_LO) && (n_accum <= CP_DIGIT_HI);
	assign allowed  = is_us || is_digit
		|| ((n_accum >= CP_LOWER_LO) && (n_accum <= CP_LOWER_HI))
		|| ((n_accum >= CP_CJK_LO) && (n_accum <= CP_CJK_HI))
		|| (n_accum == CP_PAREN_L) || (n_accum == CP_PAREN_R);

	always_comb begin
		if (n_accum < CP_2BYTE) begin
			need = 2'd0;
		end else if (n_accum < CP_3BYTE) begin
			need = 2'd1;
		end else if (n_accum < CP_4BYTE) begin
			need = 2'd2;
		end else begin
			need = 2'd3;
		end
	end

	// decode step: byte first, then a finished sequence goes through the rule checks
	always_comb begin
		n_stopped = stopped_q;
		n_err     = err_q;
		n_pend    = pend_q;
		n_seqlen  = seqlen_q;
		n_accum   = accum_q;
		n_chars   = chars_q;
		n_lwu     = lwu_q;
		fin       = 1'b0;
		if (item.has_byte) begin
			if (stopped_q) begin
				n_lwu = 1'b0;
			end else if (pend_q == 2'd0) begin
				case (item.kind)
					KIND_ASCII: begin
						n_seqlen = 2'd0;
						n_accum  = {14'd0, item.payload};
						fin      = 1'b1;
					end
					KIND_LEAD2: begin
						n_seqlen = 2'd1;
						n_pend   = 2'd1;
						n_accum  = {14'd0, item.payload};
					end
					KIND_LEAD3: begin
						n_seqlen = 2'd2;
						n_pend   = 2'd2;
						n_accum  = {14'd0, item.payload};
					end
					KIND_LEAD4: begin
						n_seqlen = 2'd3;
						n_pend   = 2'd3;
						n_accum  = {14'd0, item.payload};
					end
					default: begin
						n_stopped = 1'b1;
						n_err     = VERDICT_BAD_UTF8;
					end
				endcase
			end else if (item.kind != KIND_CONT) begin
				n_stopped = 1'b1;
				n_err     = VERDICT_BAD_UTF8;
			end else begin
				n_accum = {accum_q[14:0], item.payload[5:0]};
				n_pend  = 2'(pend_q - 2'd1);
				fin     = (pend_q == 2'd1);
			end
		end
		if (fin) begin
			if ((n_accum > CP_MAX) || ((n_accum >= CP_SURR_LO) && (n_accum <= CP_SURR_HI))
				|| (need != n_seqlen)) begin
				n_stopped = 1'b1;
				n_err     = VERDICT_BAD_UTF8;
			end else begin
				n_chars = 9'(chars_q + 1'b1);
				// the character past the limit is not class-checked
				if (n_chars > {1'b0, limit}) begin
					n_stopped = 1'b1;
					n_err     = VERDICT_LONG;
					n_lwu     = is_us;
				end else if ((chars_q == '0) && is_us) begin
					n_stopped = 1'b1;
					n_err     = VERDICT_LEAD_UNDERLINE;
				end else if ((chars_q == '0) && is_digit) begin
					n_stopped = 1'b1;
					n_err     = VERDICT_LEAD_DIGIT;
				end else if (!allowed) begin
					n_stopped = 1'b1;
					n_err     = VERDICT_BAD_CHAR;
				end else begin
					n_lwu = is_us;
				end
			end
		end
	end

	// end of name: a sequence still open counts as bad UTF-8
	always_comb begin
		end_stop = n_stopped || (n_pend != 2'd0);
		end_err  = (!n_stopped && (n_pend != 2'd0)) ? VERDICT_BAD_UTF8 : n_err;
		if (end_stop && (end_err inside {[VERDICT_BAD_UTF8:VERDICT_BAD_CHAR]})) begin
			verdict = end_err;
		end else if ((n_chars != '0) && n_lwu) begin
			verdict = VERDICT_TRAIL_UNDERLINE;
		end else if (n_chars < {1'b0, min_chars}) begin
			verdict = VERDICT_SHORT;
		end else if (end_stop) begin
			verdict = VERDICT_LONG;
		end else begin
			verdict = VERDICT_OK;
		end
		res.verdict    = verdict;
		res.char_count = n_chars;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q <= 1'b0;
			err_q     <= VERDICT_OK;
			pend_q    <= '0;
			seqlen_q  <= '0;
			accum_q   <= '0;
			chars_q   <= '0;
			lwu_q     <= 1'b0;
		end else if (item_pop) begin
			if (item.is_end) begin
				stopped_q <= 1'b0;
				err_q     <= VERDICT_OK;
				pend_q    <= '0;
				seqlen_q  <= '0;
				accum_q   <= '0;
				chars_q   <= '0;
				lwu_q     <= 1'b0;
			end else begin
				stopped_q <= n_stopped;
				err_q     <= n_err;
				pend_q    <= n_pend;
				seqlen_q  <= n_seqlen;
				accum_q   <= n_accum;
				chars_q   <= n_chars;
				lwu_q     <= n_lwu;
			end
		end
	end
endmodule

FILE: rtl/utf8_name_rule_checker_core.sv
// Top level of the UTF-8 name rule checker: queues, front end, back end, configuration.
// Path: an end transaction goes into the item queue, is decoded by the back end and its
//   result is registered in the result queue, which drops empty. The back end decodes one
//   item per cycle; an end item waits while the result queue is full, a byte never does.
//   Throughput: one byte per cycle; two-entry item and result queues absorb stalls.
// Reset: asynchronous; clears both queues and the per-name state, min_chars to 1
//   and max_chars to 63.
`include "assert_macros.svh"

module utf8_name_rule_checker_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] name_byte,
	input  logic       has_byte,
	input  logic       is_end,
	output logic       empty,
	input  logic       pop,
	output logic [2:0] verdict,
	output logic [8:0] char_count,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);
	import unrc_pkg::*;

	logic       item_wr;
	item_t      item_in;
	logic [$bits(item_t)-1:0] item_rd;
	item_t      item_q;
	logic       item_empty;
	logic       item_pop;
	logic       res_push;
	logic       res_full;
	result_t    res_in;
	logic [$bits(result_t)-1:0] res_rd;
	result_t    res_out;
	logic [7:0] min_chars_q;
	logic [7:0] max_chars_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_chars_q <= 8'd1;
			max_chars_q <= 8'd63;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MIN_CHARS) begin
				min_chars_q <= cfg_data;
			end else begin
				max_chars_q <= cfg_data;
			end
		end
	end

	unrc_front u_front (
		.push       (push),
		.queue_full (full),
		.name_byte  (name_byte),
		.has_byte   (has_byte),
		.is_end     (is_end),
		.item_wr    (item_wr),
		.item       (item_in)
	);

	unrc_queue #(
		.WIDTH ($bits(item_t)),
		.DEPTH (2)
	) u_item_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (item_wr),
		.wr_data (item_in),
		.full    (full),
		.rd_en   (item_pop),
		.rd_data (item_rd),
		.empty   (item_empty)
	);

	assign item_q = item_t'(item_rd);

	unrc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!item_empty),
		.item       (item_q),
		.item_pop   (item_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res_in),
		.min_chars  (min_chars_q),
		.max_chars  (max_chars_q)
	);

	unrc_queue #(
		.WIDTH ($bits(result_t)),
		.DEPTH (2)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop && !empty),
		.rd_data (res_rd),
		.empty   (empty)
	);

	assign res_out    = result_t'(res_rd);
	assign verdict    = res_out.verdict;
	assign char_count = res_out.char_count;

	`ASSERT_NEVER(a_res_overflow, res_push && res_full, "result written into a full queue")
	`ASSERT_NEVER(a_item_underflow, item_pop && item_empty, "back end popped an empty item queue")
	`ASSERT_IMPL(a_byte_no_stall, !item_empty && !item_q.is_end, item_pop, "back end stalled on a byte")
	`ASSERT_IMPL(a_ok_in_bounds, !empty && (verdict == VERDICT_OK), (char_count >= 9'(min_chars_q)) && (char_count <= 9'(max_chars_q)), "ok verdict with count out of bounds")
endmodule
